@@ rtl/core/text_console_cursor_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication
`define TCCE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

@@ rtl/core/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, codes and helpers of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // screen geometry defaults
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int POS_W   = 11;
    localparam int CHAR_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CFG_IDX_W = 2;

    // character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_FG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_COLOR = 2'd2;

    // configuration reset values
    localparam logic [NIB_W-1:0] RST_TEXT_FG     = 4'hF;
    localparam logic [NIB_W-1:0] RST_TEXT_BG     = 4'h0;
    localparam logic [NIB_W-1:0] RST_BLANK_COLOR = 4'h0;

    // command codes
    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_BKSP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_MOVE  = 2'd3
    } t_mode;

    // one command request
    typedef struct packed {
        t_mode             mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  move_col;
        logic [ROW_W-1:0]  move_row;
    } t_in_item;

    // one result
    typedef struct packed {
        logic              cell_write;
        logic [POS_W-1:0]  cell_index;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic [POS_W-1:0]  cursor_pos;
        logic              clear_screen;
    } t_out_item;

    // color registers
    typedef struct packed {
        logic [NIB_W-1:0] text_fg;
        logic [NIB_W-1:0] text_bg;
        logic [NIB_W-1:0] blank_color;
    } t_cfg;

    // cursor coordinates
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cursor;

    // linear position row*cols + col, kept to the low POS_W bits
    function automatic logic [POS_W-1:0] lin_pos(input t_cursor cur,
                                                 input logic [COL_W-1:0] cols);
        logic [POS_W:0] sum;
        sum = (POS_W+1)'(cur.row) * (POS_W+1)'(cols) + (POS_W+1)'(cur.col);
        return sum[POS_W-1:0];
    endfunction

endpackage

@@ rtl/core/text_console_cursor_engine.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character console cursor engine: one cell write / cursor result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel i_in_valid / o_in_stall / i_in_data carries one command
//   (put, backspace, clear, move). Each command yields exactly one result on
//   o_out_valid / i_out_stall / o_out_data: an optional cell write, a clear
//   flag and the cursor position after the command.
//   Config channel i_cfg_valid / o_cfg_ready writes the color registers by
//   index (0 text fg, 1 text bg, 2 blank color); the port is always ready. The user
//   must write it only while no command is in flight; the block does not enforce it.
//   A command passes from the input register to the result register. Throughput:
//   one command per cycle while the receiver does not stall, set by the cursor
//   register pair which is updated as each command moves into the result
//   register.
//   Receiver stall: the result register holds; the input register still takes
//   one more command, then o_in_stall rises until the result is taken.
//   Reset: cursor goes to 0,0, colors to fg 15, bg 0, blank 0, both stages
//   empty.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command requests
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tcce_pkg::t_in_item             i_in_data,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tcce_pkg::t_out_item            o_out_data,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcce_pkg::NIB_W-1:0]     i_cfg_data
);

    localparam logic [tcce_pkg::COL_W-1:0] COL_LAST = tcce_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcce_pkg::ROW_W-1:0] ROW_LAST = tcce_pkg::ROW_W'(ROWS - 1);
    localparam logic [tcce_pkg::COL_W-1:0] COL_CNT  = tcce_pkg::COL_W'(COLUMNS);

    logic                r_in_vld;
    tcce_pkg::t_in_item  r_in;
    logic                r_out_vld;
    tcce_pkg::t_out_item r_out;
    tcce_pkg::t_cursor   r_cur;
    tcce_pkg::t_cursor   n_cur;
    tcce_pkg::t_cfg      r_cfg;
    tcce_pkg::t_out_item n_out;
    logic                w_in_acc;
    logic                w_fire;

    // handshake: move the input stage forward when the result slot frees
    assign w_fire      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !w_fire;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // command decode
    tcce_cmd #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cmd (
        .i_item (r_in),
        .i_cur  (r_cur),
        .i_cfg  (r_cfg),
        .o_nxt  (n_cur),
        .o_res  (n_out)
    );

    // stage valids and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cur     <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire) begin
                r_out_vld <= 1'b1;
                r_cur     <= n_cur;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_fg     <= tcce_pkg::RST_TEXT_FG;
            r_cfg.text_bg     <= tcce_pkg::RST_TEXT_BG;
            r_cfg.blank_color <= tcce_pkg::RST_BLANK_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tcce_pkg::CFG_TEXT_FG:     r_cfg.text_fg     <= i_cfg_data;
                tcce_pkg::CFG_TEXT_BG:     r_cfg.text_bg     <= i_cfg_data;
                tcce_pkg::CFG_BLANK_COLOR: r_cfg.blank_color <= i_cfg_data;
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    // checks
    `include "text_console_cursor_engine_assert.svh"

    `TCCE_ASSERT_IMPL(a_cursor_range, 1'b1, r_cur.col <= COL_LAST && r_cur.row <= ROW_LAST)
    `TCCE_ASSERT_IMPL(a_write_xor_clear, r_out_vld, !(r_out.cell_write && r_out.clear_screen))
    `TCCE_ASSERT_IMPL(a_clear_homes, r_out_vld && r_out.clear_screen, r_out.cursor_pos == '0)
    `TCCE_ASSERT_NEXT(a_pos_tracks_cursor, w_fire, r_out.cursor_pos == tcce_pkg::lin_pos(r_cur, COL_CNT))

endmodule

@@ rtl/core/tcce_cmd.sv @@
// ----------------------------------------------------------------------------
// tcce_cmd
// Command decode: next cursor and result fields for one command.
// ----------------------------------------------------------------------------
module tcce_cmd #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  tcce_pkg::t_in_item  i_item,
    input  tcce_pkg::t_cursor   i_cur,
    input  tcce_pkg::t_cfg      i_cfg,
    output tcce_pkg::t_cursor   o_nxt,
    output tcce_pkg::t_out_item o_res
);

    localparam logic [tcce_pkg::COL_W-1:0] COL_LAST = tcce_pkg::COL_W'(COLUMNS - 1);
    localparam logic [tcce_pkg::ROW_W-1:0] ROW_LAST = tcce_pkg::ROW_W'(ROWS - 1);
    localparam logic [tcce_pkg::COL_W-1:0] COL_CNT  = tcce_pkg::COL_W'(COLUMNS);

    logic [tcce_pkg::ROW_W-1:0]  w_row_inc;
    logic [tcce_pkg::POS_W-1:0]  w_pos_cur;
    logic [tcce_pkg::POS_W-1:0]  w_pos_nxt;
    logic [tcce_pkg::CHAR_W-1:0] w_blank_attr;
    tcce_pkg::t_cursor           w_nxt;
    tcce_pkg::t_out_item         w_res;

    // row advance with wrap, no scrolling
    assign w_row_inc    = (i_cur.row >= ROW_LAST) ? '0 : i_cur.row + 1'b1;
    assign w_blank_attr = {i_cfg.blank_color, i_cfg.blank_color};
    assign w_pos_cur    = tcce_pkg::lin_pos(i_cur, COL_CNT);
    assign w_pos_nxt    = tcce_pkg::lin_pos(w_nxt, COL_CNT);

    // next cursor
    always_comb begin
        w_nxt = i_cur;
        unique case (i_item.mode)
            tcce_pkg::MODE_PUT: begin
                if (i_item.char_code == tcce_pkg::NEWLINE_CODE || i_cur.col >= COL_LAST) begin
                    w_nxt.col = '0;
                    w_nxt.row = w_row_inc;
                end else begin
                    w_nxt.col = i_cur.col + 1'b1;
                end
            end
            tcce_pkg::MODE_BKSP: begin
                if (i_cur.col != '0) begin
                    w_nxt.col = i_cur.col - 1'b1;
                end else if (i_cur.row != '0) begin
                    w_nxt.row = i_cur.row - 1'b1;
                    w_nxt.col = COL_LAST;
                end
            end
            tcce_pkg::MODE_CLEAR: begin
                w_nxt = '0;
            end
            tcce_pkg::MODE_MOVE: begin
                w_nxt.col = (i_item.move_col > COL_LAST) ? COL_LAST : i_item.move_col;
                w_nxt.row = (i_item.move_row > ROW_LAST) ? ROW_LAST : i_item.move_row;
            end
            default: w_nxt = i_cur;
        endcase
    end

    // result fields
    always_comb begin
        w_res            = '0;
        w_res.cursor_pos = w_pos_nxt;
        unique case (i_item.mode)
            tcce_pkg::MODE_PUT: begin
                if (i_item.char_code != tcce_pkg::NEWLINE_CODE) begin
                    w_res.cell_write = 1'b1;
                    w_res.cell_index = w_pos_cur;
                    w_res.cell_char  = i_item.char_code;
                    w_res.cell_attr  = {i_cfg.text_fg, i_cfg.text_bg};
                end
            end
            tcce_pkg::MODE_BKSP: begin
                // nothing happens at the origin
                if (i_cur.col != '0 || i_cur.row != '0) begin
                    w_res.cell_write = 1'b1;
                    w_res.cell_index = w_pos_nxt;
                    w_res.cell_char  = tcce_pkg::SPACE_CODE;
                    w_res.cell_attr  = w_blank_attr;
                end
            end
            tcce_pkg::MODE_CLEAR: begin
                // fill value travels with the clear flag
                w_res.clear_screen = 1'b1;
                w_res.cell_char    = tcce_pkg::SPACE_CODE;
                w_res.cell_attr    = w_blank_attr;
            end
            tcce_pkg::MODE_MOVE: begin
                w_res.cell_write = 1'b0;
            end
            default: w_res.cell_write = 1'b0;
        endcase
    end

    assign o_nxt = w_nxt;
    assign o_res = w_res;

endmodule
